[hw/rtl/fsq_pkg.sv]
package fsq_pkg;

    localparam logic [31:0] ABS_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
    localparam logic [31:0] QNAN      = 32'h7fc0_0000;
    localparam logic [31:0] HALF_BIAS = 32'h3f00_0000;
    localparam logic [8:0]  EXP_BIAS  = 9'd127;

    localparam int FRAC_W = 23;
    localparam int SIG_W  = 24;   // significand with hidden bit
    localparam int DIG_W  = 25;   // root digits, one per iteration
    localparam int ROOT_W = 26;   // root plus room for the round carry
    localparam int ACC_W  = 27;   // twice the partial root
    localparam int REM_W  = 28;   // partial remainder

    typedef struct packed {
        logic load;
        logic shift;
    } fsq_norm_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic round;
    } fsq_root_ctl_t;

endpackage

[hw/rtl/fsq_operand_if.sv]
interface fsq_operand_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;

    modport source (output valid, output operand_bits, input ready);
    modport sink   (input valid, input operand_bits, output ready);
endinterface

[hw/rtl/fsq_root_if.sv]
interface fsq_root_if;
    logic        valid;
    logic        ready;
    logic [31:0] root_bits;

    modport source (output valid, output root_bits, input ready);
    modport sink   (input valid, input root_bits, output ready);
endinterface

[hw/rtl/fsq_norm.sv]
// Subnormal normalizer: one left shift per cycle until the hidden bit is set.
module fsq_norm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsq_pkg::fsq_norm_ctl_t              ctl,
    input  logic [31:0]                         operand_bits,
    output logic [fsq_pkg::SIG_W-1:0]           sig,
    output logic [8:0]                          exp_b,
    output logic                                normalized
);
    import fsq_pkg::*;

    logic [SIG_W-1:0] sig_reg, sig_next;
    logic [8:0]       exp_reg, exp_next;   // biased exponent, two's complement
    logic [7:0]       exp_field;
    logic [FRAC_W-1:0] frac;

    assign exp_field = operand_bits[30:23];
    assign frac      = operand_bits[FRAC_W-1:0];

    always_comb
    begin
        sig_next = sig_reg;
        exp_next = exp_reg;
        if (ctl.load)
        begin
            if (exp_field == 8'd0)
            begin
                sig_next = {1'b0, frac};
                exp_next = 9'd1;
            end
            else
            begin
                sig_next = {1'b1, frac};
                exp_next = {1'b0, exp_field};
            end
        end
        else if (ctl.shift)
        begin
            sig_next = {sig_reg[SIG_W-2:0], 1'b0};
            exp_next = exp_reg - 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg <= '0;
            exp_reg <= '0;
        end
        else
        begin
            sig_reg <= sig_next;
            exp_reg <= exp_next;
        end
    end

    assign sig        = sig_reg;
    assign exp_b      = exp_reg;
    assign normalized = sig_reg[SIG_W-1];

endmodule

[hw/rtl/fsq_root_unit.sv]
// Restoring digit-by-digit root around one shared subtractor.
// The same subtractor does the round-up (root - (-1)) after the last digit.
module fsq_root_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsq_pkg::fsq_root_ctl_t              ctl,
    input  logic [fsq_pkg::ROOT_W-1:0]          init_rem,
    output logic [fsq_pkg::ROOT_W-1:0]          root,
    output logic                                last_digit
);
    import fsq_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DIG_W-1:0]  bit_reg, bit_next;

    logic [ACC_W-1:0]  trial;
    logic [REM_W-1:0]  sub_a, sub_b;
    logic [REM_W:0]    diff;
    logic              rnd_up;

    // acc only holds bits above the current digit, so OR is the add
    assign trial  = acc_reg | {2'b00, bit_reg};
    assign rnd_up = (rem_reg != '0) && root_reg[0];

    always_comb
    begin
        if (ctl.round)
        begin
            sub_a = {2'b00, root_reg};
            sub_b = rnd_up ? '1 : '0;
        end
        else
        begin
            sub_a = rem_reg;
            sub_b = {1'b0, trial};
        end
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (ctl.load)
        begin
            rem_next  = {2'b00, init_rem};
            acc_next  = '0;
            root_next = '0;
            bit_next  = {1'b1, {(DIG_W-1){1'b0}}};
        end
        else if (ctl.step)
        begin
            bit_next = {1'b0, bit_reg[DIG_W-1:1]};
            if (!diff[REM_W])
            begin
                rem_next  = {diff[REM_W-2:0], 1'b0};
                acc_next  = acc_reg | {1'b0, bit_reg, 1'b0};
                root_next = root_reg | {1'b0, bit_reg};
            end
            else
            begin
                rem_next = {rem_reg[REM_W-2:0], 1'b0};
            end
        end
        else if (ctl.round)
        begin
            root_next = diff[ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            acc_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            root_reg <= root_next;
            bit_reg  <= bit_next;
        end
    end

    assign root       = root_reg;
    assign last_digit = bit_reg[0];

endmodule

[hw/rtl/float32_square_root.sv]
// Channel   Dir   Payload              Transfer
// operand   in    operand_bits [31:0]  valid && ready
// root      out   root_bits    [31:0]  valid && ready
//
// Normal operand: after the operand transfer come the normalize check,
// 25 root digits, the round on the shared subtractor and the pack; then root is valid.
// Subnormal operand: 1 to 23 normalizing left shifts come before the root digits.
// Zero, negative, infinity, NaN: root valid the cycle after the transfer.
// One item at a time: ready is high only while idle; a new operand is taken
// the cycle after the root transfer. Reset returns to idle with no result pending.
module float32_square_root (
    input  logic          clk,
    input  logic          rst_n,
    fsq_operand_if.sink   operand,
    fsq_root_if.source    root
);
    import fsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_ROOT,
        S_ROUND,
        S_PACK,
        S_OUT
    } state_t;

    state_t        state_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic [7:0]    eh_reg;          // floor(e / 2), signed

    fsq_norm_ctl_t norm_ctl;
    fsq_root_ctl_t root_ctl;

    logic [SIG_W-1:0]  sig;
    logic [8:0]        exp_b;
    logic              normalized;
    logic [8:0]        e_unb;
    logic [ROOT_W-1:0] init_rem;
    logic [ROOT_W-1:0] root_val;
    logic              last_digit;
    logic              accept;
    logic              is_zero;
    logic              is_nan;
    logic [31:0]       packed_bits;

    assign accept  = operand.valid && operand.ready;
    assign is_zero = (operand.operand_bits & ABS_MASK) == '0;
    assign is_nan  = operand.operand_bits >= INF_BITS;

    fsq_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (norm_ctl),
        .operand_bits (operand.operand_bits),
        .sig          (sig),
        .exp_b        (exp_b),
        .normalized   (normalized)
    );

    // odd exponent doubles the significand; both cases then double once more
    assign e_unb    = exp_b - EXP_BIAS;
    assign init_rem = e_unb[0] ? {sig, 2'b00} : {1'b0, sig, 1'b0};

    fsq_root_unit u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (root_ctl),
        .init_rem   (init_rem),
        .root       (root_val),
        .last_digit (last_digit)
    );

    assign packed_bits = {7'd0, root_val[ROOT_W-1:1]} + HALF_BIAS
                       + {{1{eh_reg[7]}}, eh_reg, 23'd0};

    always_comb
    begin
        norm_ctl.load  = accept && !is_zero && !is_nan;
        norm_ctl.shift = (state_reg == S_NORM) && !normalized;
        root_ctl.load  = (state_reg == S_NORM) && normalized;
        root_ctl.step  = (state_reg == S_ROOT);
        root_ctl.round = (state_reg == S_ROUND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            eh_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_zero)
                        begin
                            out_data_reg  <= operand.operand_bits;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else if (is_nan)
                        begin
                            out_data_reg  <= QNAN;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    if (normalized)
                    begin
                        eh_reg    <= e_unb[8:1];
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (last_digit)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    state_reg <= S_PACK;
                end
                S_PACK:
                begin
                    out_data_reg  <= packed_bits;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (root.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    out_valid_reg <= 1'b0;
                    state_reg     <= S_IDLE;
                end
            endcase
        end
    end

    assign operand.ready  = (state_reg == S_IDLE);
    assign root.valid     = out_valid_reg;
    assign root.root_bits = out_data_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(operand.ready && root.valid))
        else $error("operand taken while a root is pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !operand.ready)
        else $error("ready right after an operand transfer");

    a_nan_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_nan && !is_zero) |=> (root.valid && root.root_bits == QNAN))
        else $error("special operand did not give quiet NaN");

    a_root_needs_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> normalized)
        else $error("root digits started on unnormalized significand");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

    import fsq_pkg::*;

    localparam logic [31:0] FRAC_MASK  = 32'h007f_ffff;
    localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
    localparam logic [31:0] TOP_DIGIT  = 32'h0100_0000;
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          LONG_HOLD    = 400;

    logic clk;
    logic rst_n;

    fsq_operand_if operand_ch ();
    fsq_root_if    root_ch ();

    float32_square_root u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .root    (root_ch)
    );

    logic [31:0] pending_roots [$];
    int          root_errors = 0;
    int          burst_left  = 0;
    int          long_hold_req = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Square root by restoring digit recurrence, round to nearest even.
    function automatic logic [31:0] sqrt_bits_of(input logic [31:0] x);
        logic [31:0] sig;
        logic [31:0] rem;
        logic [31:0] acc;
        logic [31:0] trial;
        logic [31:0] digits;
        logic [31:0] weight;
        int          e;
        int          shifts;
        if ((x & ABS_MASK) == 32'd0)
            return x;
        if (x >= INF_BITS)
            return QNAN;
        sig = x;
        e   = int'(x[30:23]);
        if (e == 0)
        begin
            shifts = 0;
            while (sig[23] == 1'b0)
            begin
                sig = sig << 1;
                shifts++;
            end
            e = 1 - shifts;
        end
        e   = e - 127;
        sig = (sig & FRAC_MASK) | HIDDEN_BIT;
        if (e[0])
            sig = sig + sig;
        e   = e >>> 1;          // floor halving
        sig = sig + sig;
        rem    = sig;
        acc    = 32'd0;
        digits = 32'd0;
        for (weight = TOP_DIGIT; weight != 32'd0; weight = weight >> 1)
        begin
            trial = acc + weight;
            if (trial <= rem)
            begin
                acc    = trial + weight;
                rem    = rem - trial;
                digits = digits + weight;
            end
            rem = rem + rem;
        end
        if (rem != 32'd0)
            digits = digits + (digits & 32'd1);
        return (digits >> 1) + HALF_BIAS + (32'(e) << 23);
    endfunction

    // Operand side: every transfer queues its expected root.
    always @(posedge clk)
    begin
        if (operand_ch.valid && operand_ch.ready)
            pending_roots.push_back(sqrt_bits_of(operand_ch.operand_bits));
    end

    // Root side: compare each transfer with the oldest expectation.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (root_ch.valid && root_ch.ready)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected root transfer, expected none, actual %08h",
                         $time, root_ch.root_bits);
                root_errors++;
            end
            else
            begin
                want = pending_roots.pop_front();
                if (root_ch.root_bits !== want)
                begin
                    $display("%0t: root_bits mismatch, expected %08h, actual %08h",
                             $time, want, root_ch.root_bits);
                    root_errors++;
                end
            end
        end
    end

    // Receiver: duty cycle is redrawn at the start of each phase; a requested hold wins.
    always @(posedge clk)
    begin
        int hold_left;
        int phase_cycles;
        int ready_pct;
        if (long_hold_req != 0)
        begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (phase_cycles == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
            phase_cycles = 256;
        end
        phase_cycles--;
        if (hold_left > 0)
        begin
            hold_left--;
            root_ch.ready <= 1'b0;
        end
        else
            root_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    task automatic send_operand(input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                operand_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        operand_ch.valid        <= 1'b1;
        operand_ch.operand_bits <= value;
        @(posedge clk);
        while (!operand_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drops valid, lets the last transfer be queued, then waits until no root is pending.
    task automatic wait_for_roots();
        operand_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_normal();
        logic [31:0] frac;
        case ($urandom_range(0, 7))
            0: frac = 32'd0;
            1: frac = FRAC_MASK;
            default: frac = $urandom & FRAC_MASK;
        endcase
        return (32'($urandom_range(1, 254)) << 23) | frac;
    endfunction

    function automatic logic [31:0] random_subnormal();
        logic [31:0] frac;
        frac = ($urandom & FRAC_MASK) >> $urandom_range(0, 22);
        if (frac == 32'd0)
            frac = 32'd1;
        return frac;
    endfunction

    task automatic test_directed_operands();
        logic [31:0] list [] = '{
            32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002,
            32'h0040_0000, 32'h007f_ffff, 32'h0080_0000, 32'h0080_0001,
            32'h3e80_0000, 32'h3f7f_ffff, 32'h3f80_0000, 32'h4000_0000,
            32'h4040_0000, 32'h4080_0000, 32'h4110_0000, 32'h7f7f_ffff,
            32'h7f80_0000, 32'h7f80_0001, 32'h7fc0_0000, 32'h7fff_ffff,
            32'h8000_0001, 32'hbf80_0000, 32'hff80_0000, 32'hffff_ffff
        };
        foreach (list[i])
            send_operand(list[i]);
    endtask

    task automatic test_normal_operands(input int count);
        repeat (count)
            send_operand(random_normal());
    endtask

    task automatic test_subnormal_operands(input int count);
        repeat (count)
            send_operand(random_subnormal());
    endtask

    // Zeros, negatives, infinities and NaNs with random payloads.
    task automatic test_special_operands(input int count);
        logic [31:0] value;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: value = $urandom_range(0, 1) ? SIGN_BIT : 32'd0;
                1: value = SIGN_BIT | $urandom;
                2: value = INF_BITS | ($urandom & FRAC_MASK);
                default: value = ($urandom_range(0, 1) ? SIGN_BIT : 32'd0)
                                 | INF_BITS | ($urandom & FRAC_MASK);
            endcase
            send_operand(value);
        end
    endtask

    task automatic test_any_pattern(input int count);
        repeat (count)
            send_operand($urandom);
    endtask

    // Receiver holds off while the sender keeps offering.
    task automatic test_root_backpressure(input int count);
        long_hold_req = LONG_HOLD;
        repeat (count)
            send_operand(random_normal());
    endtask

    // Sender drains completely between groups.
    task automatic test_paused_sender(input int groups);
        repeat (groups)
        begin
            repeat ($urandom_range(20, 40))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_operand(random_subnormal());
                else
                    send_operand(random_normal());
            end
            wait_for_roots();
        end
    endtask

    initial
    begin
        operand_ch.valid        = 1'b0;
        operand_ch.operand_bits = 32'd0;
        root_ch.ready           = 1'b0;
        rst_n                   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_operands();
        test_normal_operands(700);
        test_subnormal_operands(200);
        test_special_operands(150);
        test_root_backpressure(40);
        test_any_pattern(400);
        test_paused_sender(8);

        wait_for_roots();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (root_errors == 0 && pending_roots.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
